FILE: sv/sslr_pkg.sv
// ----------------------------------------------------------------------------
// sslr_pkg
// Shared types, constants and helper functions for the line report search.
// ----------------------------------------------------------------------------
package sslr_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int WIN_DEPTH   = PATTERN_MAX + 1;
    localparam int SEEN_W      = $clog2(WIN_DEPTH + 1);
    localparam int PLEN_W      = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int LINE_W      = 24;
    localparam int COL_W       = 16;

    localparam logic [LINE_W-1:0] LINE_MAX_VAL = '1;
    localparam logic [COL_W-1:0]  COL_MAX_VAL  = '1;
    localparam logic [7:0]        CHAR_NL      = 8'h0A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO   = 3'd0,
        CFG_PAT_HI   = 3'd1,
        CFG_PAT_LEN  = 3'd2,
        CFG_CASE     = 3'd3,
        CFG_WORD     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic eq;
        logic nl;
        logic bnd;
    } t_cell_stat;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        logic [COL_W-1:0]  match_column;
    } t_result;

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        if (c inside {[8'h61:8'h7A]}) begin
            return c - 8'd32;
        end
        return c;
    endfunction

    function automatic logic is_boundary(input logic [7:0] c);
        return !(c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], 8'h5F});
    endfunction

    // Pattern byte that lines up with window cell k for a given length
    function automatic logic [7:0] pat_for_cell(input logic [63:0] lo,
                                                input logic [63:0] hi,
                                                input logic [PLEN_W-1:0] len,
                                                input int k);
        int i;
        i = int'(len) - 1 - k;
        if (i < 0 || i >= PATTERN_MAX) begin
            return 8'h00;
        end
        if (i < 8) begin
            return lo[8*i +: 8];
        end
        if (i < 16) begin
            return hi[8*(i-8) +: 8];
        end
        return 8'h00;
    endfunction

endpackage

FILE: sv/sslr_if.sv
// ----------------------------------------------------------------------------
// sslr_if
// Request channels: document bytes in, line reports out.
// ----------------------------------------------------------------------------
interface sslr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_document;

    modport source (output valid, output data_byte, output end_of_document, input ready);
    modport sink   (input valid, input data_byte, input end_of_document, output ready);
endinterface

interface sslr_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] line_number;
    logic [15:0] match_column;

    modport source (output valid, output line_number, output match_column, input ready);
    modport sink   (input valid, input line_number, input match_column, output ready);
endinterface

FILE: sv/sslr_cell.sv
// ----------------------------------------------------------------------------
// sslr_cell
// One window cell: holds a byte, shifts it on, compares it to its pattern byte.
// ----------------------------------------------------------------------------
module sslr_cell (
    input  logic                   i_clk,
    input  logic                   i_shift,
    input  logic [7:0]             i_byte,
    input  logic [7:0]             i_pat,
    input  logic                   i_match_case,
    output logic [7:0]             o_byte,
    output sslr_pkg::t_cell_stat   o_stat
);
    import sslr_pkg::*;

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    always_comb begin
        o_byte     = r_byte;
        o_stat.eq  = i_match_case ? (r_byte == i_pat)
                                  : (fold_upper(r_byte) == fold_upper(i_pat));
        o_stat.nl  = (r_byte == CHAR_NL);
        o_stat.bnd = is_boundary(r_byte);
    end

endmodule

FILE: sv/sslr_outq.sv
// ----------------------------------------------------------------------------
// sslr_outq
// Two-entry result queue between the decision logic and the output channel.
// ----------------------------------------------------------------------------
module sslr_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sslr_pkg::t_result   i_res,
    output logic                o_full,
    sslr_out_if.source          o_out
);
    import sslr_pkg::*;

    t_result     r_ent [2];
    logic        r_head;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        n_head;
    logic        pop;
    logic        wr_idx;

    assign pop    = o_out.valid && o_out.ready;
    assign wr_idx = r_head ^ r_cnt[0];
    assign o_full = (r_cnt == 2'd2);

    always_comb begin
        n_cnt  = r_cnt + {1'b0, i_push} - {1'b0, pop};
        n_head = pop ? ~r_head : r_head;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_head <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[wr_idx] <= i_res;
        end
    end

    assign o_out.valid        = (r_cnt != 2'd0);
    assign o_out.line_number  = r_ent[r_head].line_number;
    assign o_out.match_column = r_ent[r_head].match_column;

endmodule

FILE: sv/substring_search_line_report.sv
// One byte request accepted per cycle, without bubbles, while the result queue is not full.
// A position is decided when the byte after its match arrives (pattern_length
// requests after the match start); its report is written into the result queue.
// A two-entry result queue lets input continue while a report waits.
// Synchronous active-low reset clears configuration, counters and the queue.
// ----------------------------------------------------------------------------
// substring_search_line_report
// Streaming pattern search over a row of window cells; reports line and column.
// ----------------------------------------------------------------------------
module substring_search_line_report (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sslr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sslr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    sslr_in_if.sink                           i_in,
    sslr_out_if.source                        o_out
);
    import sslr_pkg::*;

    logic [63:0]         r_pat_lo;
    logic [63:0]         r_pat_hi;
    logic [PLEN_W-1:0]   r_len;
    logic                r_case;
    logic                r_word;

    logic [SEEN_W-1:0]   r_seen, n_seen;
    logic [LINE_W-1:0]   r_line, n_line;
    logic [COL_W-1:0]    r_col, n_col;
    logic                r_skip, n_skip;

    logic [7:0]          win_byte [WIN_DEPTH];
    logic [7:0]          win_pat  [WIN_DEPTH];
    t_cell_stat          win_stat [WIN_DEPTH];

    logic                accept, term, shift, full;
    logic                len_ok, decide, all_eq, first_nl, start_bnd;
    logic                start_ok, end_ok, hit;
    t_result             res;

    assign term   = i_in.end_of_document;
    assign accept = i_in.valid && i_in.ready;
    assign shift  = accept && !term;
    assign i_in.ready = !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_len    <= '0;
            r_case   <= 1'b0;
            r_word   <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PAT_LO:  r_pat_lo <= i_cfg_data[63:0];
                CFG_PAT_HI:  r_pat_hi <= i_cfg_data[63:0];
                CFG_PAT_LEN: r_len    <= i_cfg_data[PLEN_W-1:0];
                CFG_CASE:    r_case   <= i_cfg_data[0];
                CFG_WORD:    r_word   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
        assign win_pat[k] = pat_for_cell(r_pat_lo, r_pat_hi, r_len, k);
        sslr_cell u_cell (
            .i_clk        (i_clk),
            .i_shift      (shift),
            .i_byte       ((k == 0) ? i_in.data_byte : win_byte[(k == 0) ? 0 : k-1]),
            .i_pat        (win_pat[k]),
            .i_match_case (r_case),
            .o_byte       (win_byte[k]),
            .o_stat       (win_stat[k])
        );
    end

    always_comb begin
        all_eq    = 1'b1;
        first_nl  = 1'b0;
        start_bnd = 1'b0;
        for (int k = 0; k < WIN_DEPTH; k++) begin
            if (k < int'(r_len) && !win_stat[k].eq) begin
                all_eq = 1'b0;
            end
            if (k == int'(r_len) - 1) begin
                first_nl = win_stat[k].nl;
            end
            if (k == int'(r_len)) begin
                start_bnd = win_stat[k].bnd;
            end
        end
    end

    always_comb begin
        len_ok   = (r_len != '0) && (int'(r_len) <= PATTERN_MAX);
        decide   = accept && len_ok && (int'(r_seen) >= int'(r_len));
        start_ok = !r_word || (int'(r_seen) < int'(r_len) + 1) || start_bnd;
        end_ok   = !r_word || term || is_boundary(i_in.data_byte);
        hit      = 1'b0;

        n_line = r_line;
        n_col  = r_col;
        n_skip = r_skip;
        n_seen = r_seen;

        if (decide) begin
            if (first_nl) begin
                if (r_line != LINE_MAX_VAL) begin
                    n_line = r_line + 1'b1;
                end
                n_col  = '0;
                n_skip = 1'b0;
            end else begin
                if (!r_skip && all_eq) begin
                    n_skip = 1'b1;
                    hit    = start_ok && end_ok;
                end
                if (r_col != COL_MAX_VAL) begin
                    n_col = r_col + 1'b1;
                end
            end
        end

        if (accept) begin
            if (term) begin
                n_line = '0;
                n_col  = '0;
                n_skip = 1'b0;
                n_seen = '0;
            end else if (int'(r_seen) < WIN_DEPTH) begin
                n_seen = r_seen + 1'b1;
            end
        end

        res.line_number  = (r_line == LINE_MAX_VAL) ? LINE_MAX_VAL : r_line + 1'b1;
        res.match_column = r_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_line <= '0;
            r_col  <= '0;
            r_skip <= 1'b0;
        end else begin
            r_seen <= n_seen;
            r_line <= n_line;
            r_col  <= n_col;
            r_skip <= n_skip;
        end
    end

    sslr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (hit),
        .i_res   (res),
        .o_full  (full),
        .o_out   (o_out)
    );

endmodule
